@@ src/cvs_pkg.sv @@
// ----------------------------------------------------------------------------
// cvs_pkg: shared types and constants of the cache victim selector
// Holds table geometry, action and status codes and the channel payloads.
// ----------------------------------------------------------------------------
`default_nettype none
package cvs_pkg;
  localparam int SLOTS     = 64;
  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int TIME_BITS = 32;
  localparam int SIZE_BITS = 32;
  localparam int CNT_BITS  = 32;

  typedef enum logic [1:0] {
    ACT_INSTALL = 2'd0,
    ACT_USE     = 2'd1,
    ACT_REMOVE  = 2'd2,
    ACT_EVICT   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_EVICTED = 2'd1,
    ST_NONE    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    POL_LRU  = 2'd0,
    POL_LFU  = 2'd1,
    POL_FIFO = 2'd2
  } policy_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  slot;
    logic [1:0]  obj_type;
    logic [31:0] obj_size;
    logic        sticky;
    logic [31:0] stamp;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] victim_slot;
  } rsp_t;

  // Token handed down the chain: an access or an eviction probe with its best
  typedef struct packed {
    logic                 vld;
    logic [1:0]           action;
    logic [SLOT_BITS-1:0] slot;
    logic [1:0]           obj_type;
    logic [31:0]          obj_size;
    logic                 sticky;
    logic [TIME_BITS-1:0] stamp;
    logic [1:0]           policy;
    logic                 found;
    logic [SLOT_BITS-1:0] best;
    logic [63:0]          best_key;
  } tok_t;
endpackage
`default_nettype wire

@@ src/cvs_if.sv @@
// ----------------------------------------------------------------------------
// cvs_word_if: valid/ready channel carrying one word
// Source drives valid and payload, sink drives ready.
// ----------------------------------------------------------------------------
`default_nettype none
interface cvs_word_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/cvs_cell.sv @@
// ----------------------------------------------------------------------------
// cvs_cell: one table slot
// Holds one entry, applies accesses aimed at it, folds itself into probes.
// ----------------------------------------------------------------------------
`default_nettype none
module cvs_cell
  import cvs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [SLOT_BITS-1:0] idx,
  input  wire tok_t tin,
  input  wire logic kill,
  input  wire logic [SLOT_BITS-1:0] kill_slot,
  output tok_t      tout
);
  logic                 valid;
  logic                 stk;
  logic [1:0]           typ;
  logic [SIZE_BITS-1:0] size;
  logic [TIME_BITS-1:0] t_inst;
  logic [TIME_BITS-1:0] t_use;
  logic [CNT_BITS-1:0]  cnt;
  logic [63:0]          key;
  logic                 elig;
  logic                 hit;
  tok_t                 nxt;

  assign hit = tin.vld && tin.slot == idx;

  always_comb begin
    case (tin.policy)
      POL_LFU:  key = 64'(cnt);
      POL_FIFO: key = 64'(t_inst);
      default:  key = 64'(t_use);
    endcase
    elig = valid && !stk && typ == tin.obj_type && 64'(size) >= 64'(tin.obj_size);
    nxt = tin;
    if (tin.vld && tin.action == ACT_EVICT && elig && (!tin.found || key < tin.best_key)) begin
      nxt.found    = 1'b1;
      nxt.best     = idx;
      nxt.best_key = key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      tout.vld <= 1'b0;
    end else begin
      tout.vld <= tin.vld;
      if (kill && kill_slot == idx) begin
        valid <= 1'b0;
      end else if (hit && tin.action == ACT_INSTALL) begin
        valid <= 1'b1;
      end else if (hit && tin.action == ACT_REMOVE) begin
        valid <= 1'b0;
      end
    end
    tout.action   <= nxt.action;
    tout.slot     <= nxt.slot;
    tout.obj_type <= nxt.obj_type;
    tout.obj_size <= nxt.obj_size;
    tout.sticky   <= nxt.sticky;
    tout.stamp    <= nxt.stamp;
    tout.policy   <= nxt.policy;
    tout.found    <= nxt.found;
    tout.best     <= nxt.best;
    tout.best_key <= nxt.best_key;
    if (hit && tin.action == ACT_INSTALL) begin
      stk    <= tin.sticky;
      typ    <= tin.obj_type;
      size   <= tin.obj_size;
      t_inst <= tin.stamp;
      t_use  <= tin.stamp;
      cnt    <= '0;
    end else if (hit && tin.action == ACT_USE && valid) begin
      t_use <= tin.stamp;
      if (cnt != '1) begin
        cnt <= cnt + CNT_BITS'(1);
      end
    end
  end
endmodule
`default_nettype wire

@@ src/cache_victim_selector.sv @@
// ----------------------------------------------------------------------------
// cache_victim_selector: LRU / LFU / FIFO victim selection over a slot table
// Top level: request intake, a chain of slot cells, response register.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one word per action (install, use, remove, evict request).
//   rsp  : one word per request with status and victim slot.
//   policy_we / policy_wdata : replacement key, write only while idle.
// Each request enters the head of a chain of SLOTS cells, one cell per slot,
// and moves one cell per cycle. A cell applies install/use/remove aimed at
// its slot and folds its key into an eviction probe as it passes.
// At the tail the winner of a probe is cleared in its cell.
// The response word is registered as the request leaves the chain tail.
// Only one request is in flight at a time: the pass through the cell chain
// and the response handshake must finish before the next word is taken.
// Reset clears every valid mark and the policy to least recent use; entry
// payloads stay unset until installed. A stalled receiver holds the
// response register; no new request is taken until it drains.
// ----------------------------------------------------------------------------
`default_nettype none
module cache_victim_selector
  import cvs_pkg::*;
(
  input wire logic   clk,
  input wire logic   rst,
  cvs_word_if.sink   req,
  cvs_word_if.source rsp,
  input wire logic       policy_we,
  input wire logic [1:0] policy_wdata
);
  logic [1:0] policy;
  logic       busy;
  tok_t       chain [SLOTS+1];
  tok_t       head;
  tok_t       tail;
  logic       kill;
  rsp_t       rsp_word;
  logic       rsp_valid;

  assign req.ready = !busy;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_word;

  // Inject the accepted word at the head of the chain
  always_comb begin
    head          = '0;
    head.vld      = req.valid && !busy;
    head.action   = req.data.action;
    head.slot     = req.data.slot;
    head.obj_type = req.data.obj_type;
    head.obj_size = req.data.obj_size;
    head.sticky   = req.data.sticky;
    head.stamp    = req.data.stamp;
    head.policy   = policy;
  end
  assign chain[0] = head;

  genvar g;
  generate
    for (g = 0; g < SLOTS; g++) begin : g_cell
      cvs_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .idx       (SLOT_BITS'(g)),
        .tin       (chain[g]),
        .kill      (kill),
        .kill_slot (tail.best),
        .tout      (chain[g+1])
      );
    end
  endgenerate

  assign tail = chain[SLOTS];
  // Clear the winning slot as the probe leaves the chain
  assign kill = tail.vld && tail.action == ACT_EVICT && tail.found;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy    <= POL_LRU;
      busy      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (policy_we) begin
        policy <= policy_wdata;
      end
      if (req.valid && req.ready) begin
        busy <= 1'b1;
      end
      if (tail.vld) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
        busy      <= 1'b0;
      end
    end
    if (tail.vld) begin
      if (tail.action != ACT_EVICT) begin
        rsp_word.status      <= ST_DONE;
        rsp_word.victim_slot <= '0;
      end else if (tail.found) begin
        rsp_word.status      <= ST_EVICTED;
        rsp_word.victim_slot <= 6'(tail.best);
      end else begin
        rsp_word.status      <= ST_NONE;
        rsp_word.victim_slot <= '0;
      end
    end
  end
endmodule
`default_nettype wire

@@ tb/sv/cache_victim_selector_test.sv @@
// ----------------------------------------------------------------------------
// cache_victim_selector_test: self-checking bench for the victim selector
// Drives install/use/remove/evict words under random idling on both channels,
// predicts every response word from a private copy of the slot table and
// compares status and victim slot in order.
// ----------------------------------------------------------------------------
`default_nettype none
module cache_victim_selector_test;
  import cvs_pkg::*;

  // Private image of the slot table; the predictor runs on this copy
  class victim_scoreboard;
    bit          valid_q[SLOTS];
    bit          sticky_q[SLOTS];
    logic [1:0]  type_q[SLOTS];
    logic [31:0] size_q[SLOTS];
    logic [31:0] inst_q[SLOTS];
    logic [31:0] last_q[SLOTS];
    logic [31:0] uses_q[SLOTS];
    logic [1:0]  policy;
    rsp_t        pending[$];
    int          errors;

    function new();
      policy = POL_LRU;
      errors = 0;
      foreach (valid_q[i]) valid_q[i] = 0;
    endfunction

    function logic [31:0] key_of(int s);
      if (policy == POL_LFU) return uses_q[s];
      if (policy == POL_FIFO) return inst_q[s];
      return last_q[s];
    endfunction

    // Apply one accepted request and queue the response it must produce
    function void note_request(req_t r);
      rsp_t e;
      bit hit;
      int best;
      logic [31:0] best_key;
      e = '0;
      e.status = ST_DONE;
      hit = 0;
      best = 0;
      best_key = '0;
      case (action_t'(r.action))
        ACT_EVICT: begin
          for (int s = 0; s < SLOTS; s++) begin
            if (valid_q[s] && !sticky_q[s] && type_q[s] == r.obj_type &&
                size_q[s] >= r.obj_size) begin
              if (!hit || key_of(s) < best_key) begin
                hit = 1;
                best = s;
                best_key = key_of(s);
              end
            end
          end
          if (hit) begin
            valid_q[best] = 0;
            e.status = ST_EVICTED;
            e.victim_slot = best[5:0];
          end else begin
            e.status = ST_NONE;
          end
        end
        ACT_INSTALL: begin
          valid_q[r.slot] = 1;
          sticky_q[r.slot] = r.sticky;
          type_q[r.slot] = r.obj_type;
          size_q[r.slot] = r.obj_size;
          inst_q[r.slot] = r.stamp;
          last_q[r.slot] = r.stamp;
          uses_q[r.slot] = '0;
        end
        ACT_USE: begin
          if (valid_q[r.slot]) begin
            last_q[r.slot] = r.stamp;
            if (uses_q[r.slot] != 32'hFFFF_FFFF) uses_q[r.slot]++;
          end
        end
        default: valid_q[r.slot] = 0;
      endcase
      pending.push_back(e);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        report_miss($sformatf("unexpected word status=%0d slot=%0d",
                              got.status, got.victim_slot));
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status)
        report_miss($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.victim_slot !== want.victim_slot)
        report_miss($sformatf("victim_slot got %0d want %0d",
                              got.victim_slot, want.victim_slot));
    endfunction

    function void report_miss(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic policy_we = 0;
  logic [1:0] policy_wdata = '0;
  int send_idle = 0;   // percent of cycles the sender holds off
  int recv_idle = 0;   // percent of cycles the receiver stalls

  cvs_word_if #(.word_t(req_t)) req_ch ();
  cvs_word_if #(.word_t(rsp_t)) rsp_ch ();

  victim_scoreboard board = new();

  cache_victim_selector uut (
    .clk(clk), .rst(rst), .req(req_ch.sink), .rsp(rsp_ch.source),
    .policy_we(policy_we), .policy_wdata(policy_wdata)
  );

  always #6 clk = ~clk;

  initial begin
    req_ch.valid = 0;
    req_ch.data = '0;
    rsp_ch.ready = 0;
  end

  // Receiver: stall at random, check each word taken
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) board.check_response(rsp_ch.data);
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Present one word, hold it until the handshake, then drop valid for a cycle
  task automatic send_word(req_t r);
    while ($urandom_range(99) < send_idle) @(posedge clk);
    req_ch.valid <= 1;
    req_ch.data <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    board.note_request(r);
    req_ch.valid <= 0;
    @(posedge clk);
  endtask

  // Wait for every response word, then give the chain time to settle
  task automatic wait_idle();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic write_policy(logic [1:0] p);
    wait_idle();
    policy_we <= 1;
    policy_wdata <= p;
    @(posedge clk);
    policy_we <= 0;
    board.policy = p;
  endtask

  function automatic req_t make_word(action_t a, int s, int t,
                                     logic [31:0] sz, int stk, logic [31:0] st);
    req_t r;
    r.action = a;
    r.slot = s[5:0];
    r.obj_type = t[1:0];
    r.obj_size = sz;
    r.sticky = stk[0];
    r.stamp = st;
    return r;
  endfunction

  // Random word: mostly installs and uses on a small hot set so that
  // evictions find competing candidates; sizes and stamps sometimes extreme
  function automatic req_t random_word();
    int pick;
    logic [31:0] sz, st;
    action_t a;
    pick = $urandom_range(99);
    a = pick < 35 ? ACT_INSTALL : pick < 70 ? ACT_USE : pick < 80 ? ACT_REMOVE
                                                                   : ACT_EVICT;
    case ($urandom_range(3))
      0: sz = $urandom_range(15);
      1: sz = 32'hFFFF_FFFF - $urandom_range(3);
      default: sz = $urandom;
    endcase
    st = $urandom_range(1) ? $urandom : $urandom_range(40);
    return make_word(a, $urandom_range(1) ? $urandom_range(7) : $urandom_range(63),
                     $urandom_range(3), sz, $urandom_range(9) == 0 ? 1 : 0, st);
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes, every action, tie to lowest slot, sticky, size
    send_word(make_word(ACT_EVICT, 0, 0, 0, 0, 0));              // empty table
    send_word(make_word(ACT_USE, 5, 0, 0, 0, 9));                // use invalid
    send_word(make_word(ACT_REMOVE, 5, 0, 0, 0, 0));             // remove invalid
    send_word(make_word(ACT_INSTALL, 63, 3, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF));
    send_word(make_word(ACT_INSTALL, 0, 3, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF));
    send_word(make_word(ACT_EVICT, 0, 3, 32'hFFFF_FFFF, 0, 0));   // tie: slot 0
    send_word(make_word(ACT_INSTALL, 1, 2, 100, 1, 0));           // sticky
    send_word(make_word(ACT_EVICT, 0, 2, 0, 0, 0));
    send_word(make_word(ACT_INSTALL, 2, 1, 50, 0, 10));
    send_word(make_word(ACT_INSTALL, 3, 1, 40, 0, 20));
    send_word(make_word(ACT_EVICT, 0, 1, 45, 0, 0));              // size filter
    send_word(make_word(ACT_USE, 2, 0, 0, 0, 32'hFFFF_FFFF));
    send_word(make_word(ACT_INSTALL, 4, 1, 50, 0, 5));
    send_word(make_word(ACT_EVICT, 0, 1, 0, 0, 0));
    send_word(make_word(ACT_REMOVE, 63, 0, 0, 0, 0));
    send_word(make_word(ACT_EVICT, 0, 0, 0, 0, 0));

    // Random phases under each policy, including the aliased fourth value
    for (int ph = 0; ph < 7; ph++) begin
      write_policy(2'(ph == 0 ? 3 : ph % 4));
      case (ph % 3)
        0: begin send_idle = 24; recv_idle = 58; end
        1: begin send_idle = 58; recv_idle = 24; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (int i = 0; i < 250; i++) send_word(random_word());
    end
    write_policy(POL_LRU);

    wait_idle();
    if (board.errors == 0)
      $display("cache_victim_selector: match");
    else
      $display("cache_victim_selector: mismatch");
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #40000000;
    $display("cache_victim_selector: mismatch");
    $finish;
  end
endmodule
`default_nettype wire
